// File: rtl/dbsg_pkg.sv
// Shared types and constants of the de Bruijn sequence generator.
package dbsg_pkg;

	localparam int REG_W = 5;

	localparam logic [REG_W-1:0] ORDER_RST    = 5'd4;
	localparam logic [REG_W-1:0] ALPHABET_RST = 5'd2;

	typedef enum logic {
		REG_ORDER    = 1'b0,
		REG_ALPHABET = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic clear;
		logic slot_free;
	} ctl_t;

	typedef struct packed {
		logic valid;
		logic last;
	} res_t;

endpackage

// File: rtl/dbsg_if.sv
// Request and response channel interfaces of the de Bruijn sequence generator.
interface dbsg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface dbsg_rsp_if #(
	parameter int SYMBOL_BITS = 4
);
	logic                   valid;
	logic                   ready;
	logic [SYMBOL_BITS-1:0] symbol;
	logic                   last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

// File: rtl/dbsg_word_file.sv
// Word register file: one read port, one write port, bulk clear.
module dbsg_word_file #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 clear,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < DEPTH; e++) mem_q[e] <= '0;
		end else if (clear) begin
			for (int e = 0; e < DEPTH; e++) mem_q[e] <= '0;
		end else if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = mem_q[raddr];

endmodule

// File: rtl/dbsg_seq.sv
// Prenecklace successor sequencer: emit, scan and copy over one word port.
module dbsg_seq #(
	parameter int MAX_ORDER   = 16,
	parameter int SYMBOL_BITS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [$clog2(MAX_ORDER+1)-1:0]       n_eff,
	input  logic [SYMBOL_BITS-1:0]               kmax1,
	input  dbsg_pkg::ctl_t                       ctl,
	input  logic                                 req_valid,
	input  logic                                 req_restart,
	output logic                                 req_ready,
	output dbsg_pkg::res_t                       res,
	output logic [SYMBOL_BITS-1:0]               res_symbol
);

	localparam int NW = $clog2(MAX_ORDER + 1);
	localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COPY
	} state_t;

	state_t                 state_q;
	logic [NW-1:0]          p_q;
	logic [AW-1:0]          pos_q;
	logic                   done_q;
	logic [NW-1:0]          i_q;
	logic [NW-1:0]          j_q;
	logic [AW-1:0]          src_q;
	logic [AW-1:0]          c_q;
	logic [SYMBOL_BITS-1:0] sym_q;

	logic [AW-1:0]          raddr;
	logic [SYMBOL_BITS-1:0] rdata;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [SYMBOL_BITS-1:0] wdata;
	logic                   wf_clear;

	logic                   accept;
	logic                   start;
	logic [NW-1:0]          pos_inc;
	logic [NW-1:0]          p_eff;
	logic                   wrap;
	logic [SYMBOL_BITS-1:0] sym;
	logic [NW-1:0]          i_dec;
	logic [NW-1:0]          c_inc;
	logic                   at_top;
	logic                   copy_end;

	assign req_ready = (state_q == ST_IDLE) && ctl.slot_free;
	assign accept    = req_valid && req_ready;
	assign start     = req_restart || done_q;
	assign pos_inc   = (start ? '0 : NW'(pos_q)) + NW'(1);
	assign p_eff     = start ? NW'(1) : p_q;
	assign wrap      = pos_inc >= p_eff;
	assign sym       = start ? '0 : rdata;
	assign i_dec     = i_q - NW'(1);
	assign c_inc     = NW'(c_q) + NW'(1);
	assign at_top    = (rdata == kmax1);
	assign copy_end  = (j_q == n_eff);
	assign wf_clear  = ctl.clear || (accept && start);

	always_comb begin
		raddr = pos_q;
		we    = 1'b0;
		waddr = i_dec[AW-1:0];
		wdata = rdata + SYMBOL_BITS'(1);
		unique case (state_q)
			ST_IDLE: begin
				raddr = pos_q;
			end
			ST_SCAN: begin
				raddr = i_dec[AW-1:0];
				we    = (i_q != '0) && !at_top;
			end
			ST_COPY: begin
				raddr = src_q;
				we    = !copy_end;
				waddr = j_q[AW-1:0];
				wdata = rdata;
			end
			default: begin
				raddr = pos_q;
			end
		endcase
	end

	always_comb begin
		res.valid  = 1'b0;
		res.last   = 1'b0;
		res_symbol = sym_q;
		unique case (state_q)
			ST_IDLE: begin
				res.valid  = accept && !wrap;
				res_symbol = sym;
			end
			ST_SCAN: begin
				res.valid = (i_q == '0);
				res.last  = 1'b1;
			end
			ST_COPY: begin
				res.valid = copy_end && (c_q == '0);
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	dbsg_word_file #(
		.DEPTH(MAX_ORDER),
		.WIDTH(SYMBOL_BITS)
	) u_word_file (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (wf_clear),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= NW'(1);
			pos_q   <= '0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			src_q   <= '0;
			c_q     <= '0;
			sym_q   <= '0;
		end else if (ctl.clear) begin
			state_q <= ST_IDLE;
			p_q     <= NW'(1);
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sym_q  <= sym;
						done_q <= 1'b0;
						if (start) p_q <= NW'(1);
						if (wrap) begin
							pos_q   <= '0;
							i_q     <= n_eff;
							state_q <= ST_SCAN;
						end else begin
							pos_q <= pos_inc[AW-1:0];
						end
					end
				end
				ST_SCAN: begin
					if (i_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (at_top) begin
						i_q <= i_dec;
					end else begin
						p_q     <= i_q;
						j_q     <= i_q;
						src_q   <= '0;
						c_q     <= '0;
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (copy_end) begin
						if (c_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= n_eff;
							state_q <= ST_SCAN;
						end
					end else begin
						j_q   <= j_q + NW'(1);
						src_q <= src_q + AW'(1);
						c_q   <= (c_inc == p_q) ? '0 : c_inc[AW-1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/de_bruijn_sequence_generator.sv
// Top level of the de Bruijn sequence generator: config registers, output register.
//
//   channel  dir  payload               handshake
//   req      in   restart               valid/ready
//   rsp      out  symbol, last_symbol   valid/ready
//   apb      in   order, alphabet_size  psel/penable/pwrite, pready high
//
// While the current Lyndon root still has symbols left, each taken transaction yields its symbol from the word file.
// At the end of a root the sequencer walks the word: it scans the trailing k-1 symbols,
// increments the first symbol below k-1, copies the new root over the rest of the word and
// checks whether the root length divides n, repeating until it does; its pace is bound by the
// single word file port. Async reset or any register write restarts the sequence.
// A pending result stays in the output register; a new transaction is taken as it leaves.
module de_bruijn_sequence_generator #(
	parameter int MAX_ORDER   = 16,
	parameter int SYMBOL_BITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	dbsg_req_if.sink          req,
	dbsg_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int NW   = $clog2(MAX_ORDER + 1);
	localparam int KMAX = 1 << SYMBOL_BITS;

	logic [dbsg_pkg::REG_W-1:0] order_q;
	logic [dbsg_pkg::REG_W-1:0] alphabet_size_q;
	logic                       cfg_wr;
	dbsg_pkg::reg_sel_t         reg_sel;

	logic [NW-1:0]              n_eff;
	logic [SYMBOL_BITS-1:0]     kmax1;

	logic                       out_valid_q;
	logic [SYMBOL_BITS-1:0]     out_symbol_q;
	logic                       out_last_q;

	dbsg_pkg::ctl_t             ctl;
	dbsg_pkg::res_t             res;
	logic [SYMBOL_BITS-1:0]     res_symbol;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = dbsg_pkg::reg_sel_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			dbsg_pkg::REG_ORDER:    prdata = {27'b0, order_q};
			dbsg_pkg::REG_ALPHABET: prdata = {27'b0, alphabet_size_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q         <= dbsg_pkg::ORDER_RST;
			alphabet_size_q <= dbsg_pkg::ALPHABET_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				dbsg_pkg::REG_ORDER:    order_q         <= pwdata[dbsg_pkg::REG_W-1:0];
				dbsg_pkg::REG_ALPHABET: alphabet_size_q <= pwdata[dbsg_pkg::REG_W-1:0];
				default:                order_q         <= order_q;
			endcase
		end
	end

	always_comb begin
		if (order_q == '0) begin
			n_eff = NW'(1);
		end else if ({1'b0, order_q} > 6'(MAX_ORDER)) begin
			n_eff = NW'(MAX_ORDER);
		end else begin
			n_eff = NW'(order_q);
		end
	end

	always_comb begin
		if (alphabet_size_q < 5'd2) begin
			kmax1 = SYMBOL_BITS'(1);
		end else if (10'(alphabet_size_q) > 10'(KMAX)) begin
			kmax1 = '1;
		end else begin
			kmax1 = SYMBOL_BITS'(alphabet_size_q - 5'd1);
		end
	end

	assign ctl.clear     = cfg_wr;
	assign ctl.slot_free = !out_valid_q || rsp.ready;

	dbsg_seq #(
		.MAX_ORDER  (MAX_ORDER),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.n_eff      (n_eff),
		.kmax1      (kmax1),
		.ctl        (ctl),
		.req_valid  (req.valid),
		.req_restart(req.restart),
		.req_ready  (req.ready),
		.res        (res),
		.res_symbol (res_symbol)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_symbol_q <= '0;
			out_last_q   <= 1'b0;
		end else if (res.valid) begin
			out_valid_q  <= 1'b1;
			out_symbol_q <= res_symbol;
			out_last_q   <= res.last;
		end else if (rsp.ready) begin
			out_valid_q  <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.symbol      = out_symbol_q;
	assign rsp.last_symbol = out_last_q;

	// a new result never lands on one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!out_valid_q || rsp.ready))
		else $error("result loaded over pending transaction");

	// a request is taken only when the output slot frees up
	a_accept_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> (!out_valid_q || rsp.ready))
		else $error("request accepted with output slot full");

	// after a register write the sequencer is idle and flags no last symbol
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !res.last)
		else $error("last symbol right after register write");

endmodule
